// ----- src/fkw_pkg.sv -----
// Shared constants and helpers for the Fortran record keyword scanner.
// Holds parser phase codes, result kinds, type codes and type decoding.
// No dependencies; the scanner refers to it by scoped names and the bench imports it.
package fkw_pkg;

   // parser phases
   localparam logic [2:0] PH_HEAD_MARK  = 3'd0;
   localparam logic [2:0] PH_NAME       = 3'd1;
   localparam logic [2:0] PH_COUNT      = 3'd2;
   localparam logic [2:0] PH_TYPE       = 3'd3;
   localparam logic [2:0] PH_HEAD_CLOSE = 3'd4;
   localparam logic [2:0] PH_FRAME_LEN  = 3'd5;
   localparam logic [2:0] PH_FRAME_SKIP = 3'd6;

   // result kinds
   localparam logic [1:0] KIND_RECORD = 2'd0;
   localparam logic [1:0] KIND_END    = 2'd1;
   localparam logic [1:0] KIND_FORMAT = 2'd2;
   localparam logic [1:0] KIND_FULL   = 2'd3;

   // type codes
   localparam logic [2:0] TYPE_NONE = 3'd0;
   localparam logic [2:0] TYPE_INTE = 3'd1;
   localparam logic [2:0] TYPE_REAL = 3'd2;
   localparam logic [2:0] TYPE_DOUB = 3'd3;
   localparam logic [2:0] TYPE_CHAR = 3'd4;
   localparam logic [2:0] TYPE_LOGI = 3'd5;
   localparam logic [2:0] TYPE_MESS = 3'd6;

   // four-character type tags, big-endian ASCII
   localparam logic [31:0] TAG_INTE = 32'h494E5445;
   localparam logic [31:0] TAG_REAL = 32'h5245414C;
   localparam logic [31:0] TAG_DOUB = 32'h444F5542;
   localparam logic [31:0] TAG_CHAR = 32'h43484152;
   localparam logic [31:0] TAG_LOGI = 32'h4C4F4749;
   localparam logic [31:0] TAG_MESS = 32'h4D455353;

   localparam logic [15:0] MAX_RECORDS_RESET = 16'd1024;

   function automatic logic [2:0] decode_type(input logic [31:0] tag);
      logic [2:0] code;
      case (tag)
         TAG_INTE: code = TYPE_INTE;
         TAG_REAL: code = TYPE_REAL;
         TAG_DOUB: code = TYPE_DOUB;
         TAG_CHAR: code = TYPE_CHAR;
         TAG_LOGI: code = TYPE_LOGI;
         TAG_MESS: code = TYPE_MESS;
         default:  code = TYPE_NONE;
      endcase
      return code;
   endfunction

   // elements in a frame payload: bytes divided by 1, 4 or 8 (sign bit is zero)
   function automatic logic [30:0] frame_elements(input logic [31:0] len,
                                                  input logic [2:0] code);
      logic [30:0] q;
      case (code)
         TYPE_LOGI:            q = len[30:0];
         TYPE_DOUB, TYPE_CHAR: q = {3'b000, len[30:3]};
         default:              q = {2'b00, len[30:2]};
      endcase
      return q;
   endfunction

endpackage

// ----- src/fkw_channels.sv -----
// Handshake channels of the Fortran record keyword scanner: byte input,
// result output and the max_records write port. Valid/ready on each.
// No dependencies.
interface fkw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       end_of_stream;

   modport source (output valid, data_byte, byte_present, end_of_stream, input ready);
   modport sink (input valid, data_byte, byte_present, end_of_stream, output ready);
endinterface

interface fkw_rsp_if #(
   parameter int OFFSET_WIDTH = 48,
   parameter int INDEX_WIDTH  = 16
);
   logic                    valid;
   logic                    ready;
   logic [1:0]              result_kind;
   logic [63:0]             record_name;
   logic [2:0]              type_code;
   logic [30:0]             element_count;
   logic [OFFSET_WIDTH-1:0] start_offset;
   logic [INDEX_WIDTH-1:0]  record_total;
   logic                    last_of_run;

   modport source (output valid, result_kind, record_name, type_code, element_count,
                   start_offset, record_total, last_of_run, input ready);
   modport sink (input valid, result_kind, record_name, type_code, element_count,
                 start_offset, record_total, last_of_run, output ready);
endinterface

interface fkw_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] max_records;

   modport source (output valid, max_records, input ready);
   modport sink (input valid, max_records, output ready);
endinterface

// ----- src/fortran_record_keyword_scanner.sv -----
// Fortran record keyword scanner: byte-serial parser of framed keyword files.
// A word accepted into the input register is parsed there and its results are
//   written to the result queue, which offers them. Throughput: one byte word
//   per cycle; the 8-entry result queue stalls input once five results wait
//   with a word in the parse stage, or seven with that stage empty.
//   Reset: parser idle, max_records 1024, queue empty.
// Uses fkw_pkg and the channel interfaces in fkw_channels.sv.
module fortran_record_keyword_scanner #(
   parameter int OFFSET_WIDTH = 48,
   parameter int INDEX_WIDTH  = 16
) (
   input logic        clock,
   input logic        reset,
   fkw_req_if.sink    req_bus,
   fkw_rsp_if.source  rsp_bus,
   fkw_csr_if.sink    csr_bus
);

   localparam int Q_AW    = 3;
   localparam int Q_DEPTH = 1 << Q_AW;
   localparam int CMP_W   = (INDEX_WIDTH > 16) ? INDEX_WIDTH : 16;

   typedef struct packed {
      logic [1:0]              kind;
      logic [63:0]             name;
      logic [2:0]              type_code;
      logic [30:0]             count;
      logic [OFFSET_WIDTH-1:0] offset;
      logic [INDEX_WIDTH-1:0]  total;
      logic                    last;
   } result_type;

   // ---------------------------------------------------------------
   // Input register: hold one accepted word for the parse stage.
   // ---------------------------------------------------------------
   logic       s0_valid_ff, s0_valid_in;
   logic [7:0] s0_byte_ff;
   logic       s0_present_ff, s0_eos_ff;
   logic       req_accept;

   // ---------------------------------------------------------------
   // Parser state
   // ---------------------------------------------------------------
   logic [2:0]              phase_ff, phase_in;
   logic [2:0]              fbc_ff, fbc_in;
   logic [31:0]             word_ff, word_in;
   logic [63:0]             name_ff, name_in;
   logic [2:0]              type_ff, type_in;
   logic [31:0]             declared_ff, declared_in;
   logic [32:0]             elements_ff, elements_in;
   logic [32:0]             fbl_ff, fbl_in;
   logic [OFFSET_WIDTH-1:0] offset_ff, offset_in;
   logic [OFFSET_WIDTH-1:0] start_ff, start_in;
   logic [INDEX_WIDTH-1:0]  index_ff, index_in;
   logic                    halted_ff, halted_in;
   logic [15:0]             max_records_ff, max_records_in;

   logic        take_err, take_done, table_full;
   logic [32:0] fbl_dec;
   result_type  res0, res1;
   logic [1:0]  n_res;

   // ---------------------------------------------------------------
   // Result queue
   // ---------------------------------------------------------------
   result_type            queue_ff [Q_DEPTH];
   logic [Q_AW-1:0]       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [Q_AW:0]         count_ff, count_in;
   logic                  rsp_pop;
   result_type            head;

   // Accept only with room for this word's results and the one in flight.
   assign req_bus.ready = (count_ff + {{(Q_AW-1){1'b0}}, s0_valid_ff, 1'b0})
                          <= (Q_AW+1)'(Q_DEPTH - 2);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign s0_valid_in   = req_accept;

   // Configuration is always taken.
   assign csr_bus.ready  = 1'b1;
   assign max_records_in = (csr_bus.valid) ? csr_bus.max_records : max_records_ff;

   assign table_full = (CMP_W'(index_ff) >= CMP_W'(max_records_ff)) ||
                       (index_ff == {INDEX_WIDTH{1'b1}});
   assign fbl_dec    = (fbl_ff != 33'd0) ? (fbl_ff - 33'd1) : fbl_ff;

   // ---------------------------------------------------------------
   // Parse stage: one byte, then the end-of-stream check.
   // ---------------------------------------------------------------
   always_comb begin
      phase_in    = phase_ff;
      fbc_in      = fbc_ff;
      word_in     = word_ff;
      name_in     = name_ff;
      type_in     = type_ff;
      declared_in = declared_ff;
      elements_in = elements_ff;
      fbl_in      = fbl_ff;
      offset_in   = offset_ff;
      start_in    = start_ff;
      index_in    = index_ff;
      halted_in   = halted_ff;
      take_err    = 1'b0;
      take_done   = 1'b0;
      res0        = '0;
      res1        = '0;
      n_res       = 2'd0;

      if (s0_valid_ff && !halted_ff) begin
         if (s0_present_ff) begin
            offset_in = offset_ff + OFFSET_WIDTH'(1);
            case (phase_ff)
               fkw_pkg::PH_HEAD_MARK, fkw_pkg::PH_COUNT, fkw_pkg::PH_TYPE,
               fkw_pkg::PH_HEAD_CLOSE, fkw_pkg::PH_FRAME_LEN: begin
                  // mark the record start on its first header byte
                  if (phase_ff == fkw_pkg::PH_HEAD_MARK && fbc_ff == 3'd0) begin
                     start_in = offset_ff;
                  end
                  word_in = {word_ff[23:0], s0_byte_ff};
                  if (fbc_ff < 3'd3) begin
                     fbc_in = fbc_ff + 3'd1;
                  end else begin
                     fbc_in = 3'd0;
                     case (phase_ff)
                        fkw_pkg::PH_HEAD_MARK: begin
                           name_in  = '0;
                           phase_in = fkw_pkg::PH_NAME;
                        end
                        fkw_pkg::PH_COUNT: begin
                           declared_in = word_in;
                           phase_in    = fkw_pkg::PH_TYPE;
                        end
                        fkw_pkg::PH_TYPE: begin
                           type_in  = fkw_pkg::decode_type(word_in);
                           phase_in = fkw_pkg::PH_HEAD_CLOSE;
                           if (type_in == fkw_pkg::TYPE_NONE) begin
                              take_err = 1'b1;
                           end
                        end
                        fkw_pkg::PH_HEAD_CLOSE: begin
                           if (declared_ff[31]) begin
                              take_err = 1'b1;
                           end else begin
                              elements_in = '0;
                              if (declared_ff == 32'd0) begin
                                 take_done = 1'b1;
                              end else begin
                                 phase_in = fkw_pkg::PH_FRAME_LEN;
                              end
                           end
                        end
                        default: begin
                           // frame length word
                           if (word_in[31]) begin
                              take_err = 1'b1;
                           end else begin
                              elements_in = elements_ff +
                                 {2'b00, fkw_pkg::frame_elements(word_in, type_ff)};
                              fbl_in   = {1'b0, word_in} + 33'd4;
                              phase_in = fkw_pkg::PH_FRAME_SKIP;
                           end
                        end
                     endcase
                  end
               end
               fkw_pkg::PH_NAME: begin
                  name_in = {name_ff[55:0], s0_byte_ff};
                  if (fbc_ff < 3'd7) begin
                     fbc_in = fbc_ff + 3'd1;
                  end else begin
                     fbc_in   = 3'd0;
                     phase_in = fkw_pkg::PH_COUNT;
                  end
               end
               fkw_pkg::PH_FRAME_SKIP: begin
                  fbl_in = fbl_dec;
                  if (fbl_dec == 33'd0) begin
                     if (elements_ff >= {1'b0, declared_ff}) begin
                        take_done = 1'b1;
                     end else begin
                        phase_in = fkw_pkg::PH_FRAME_LEN;
                        fbc_in   = 3'd0;
                     end
                  end
               end
               default: begin
                  take_err = 1'b1;
               end
            endcase

            if (take_err) begin
               res0      = '{kind: fkw_pkg::KIND_FORMAT, name: '0, type_code: '0,
                             count: '0, offset: start_in, total: index_ff, last: 1'b1};
               n_res     = 2'd1;
               halted_in = 1'b1;
            end else if (take_done) begin
               res0 = '{kind: (table_full ? fkw_pkg::KIND_FULL : fkw_pkg::KIND_RECORD),
                        name: name_ff, type_code: type_ff, count: declared_ff[30:0],
                        offset: start_ff, total: index_ff, last: 1'b1};
               n_res = 2'd1;
               if (table_full) begin
                  halted_in = 1'b1;
               end else begin
                  index_in = index_ff + INDEX_WIDTH'(1);
               end
               phase_in = fkw_pkg::PH_HEAD_MARK;
               fbc_in   = 3'd0;
            end
         end

         // End of stream: clean only at a record boundary.
         if (!halted_in && s0_eos_ff) begin
            halted_in = 1'b1;
            if (phase_in == fkw_pkg::PH_HEAD_MARK && fbc_in == 3'd0) begin
               res1 = '{kind: fkw_pkg::KIND_END, name: '0, type_code: '0, count: '0,
                        offset: offset_in, total: index_in, last: 1'b1};
            end else begin
               res1 = '{kind: fkw_pkg::KIND_FORMAT, name: '0, type_code: '0, count: '0,
                        offset: start_in, total: index_in, last: 1'b1};
            end
            if (n_res == 2'd0) begin
               res0  = res1;
               n_res = 2'd1;
            end else begin
               res0.last = 1'b0;
               n_res     = 2'd2;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Queue control: push up to two results, pop one per handshake.
   // ---------------------------------------------------------------
   assign head             = queue_ff[rd_ptr_ff];
   assign rsp_bus.valid    = (count_ff != '0);
   assign rsp_bus.result_kind   = head.kind;
   assign rsp_bus.record_name   = head.name;
   assign rsp_bus.type_code     = head.type_code;
   assign rsp_bus.element_count = head.count;
   assign rsp_bus.start_offset  = head.offset;
   assign rsp_bus.record_total  = head.total;
   assign rsp_bus.last_of_run   = head.last;
   assign rsp_pop   = rsp_bus.valid && rsp_bus.ready;
   assign rd_ptr_in = rsp_pop ? (rd_ptr_ff + Q_AW'(1)) : rd_ptr_ff;
   assign wr_ptr_in = wr_ptr_ff + Q_AW'(n_res);
   assign count_in  = count_ff - (Q_AW+1)'(rsp_pop) + (Q_AW+1)'(n_res);

   always_ff @(posedge clock) begin
      if (n_res != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (n_res == 2'd2) begin
         queue_ff[wr_ptr_ff + Q_AW'(1)] <= res1;
      end
      if (req_accept) begin
         s0_byte_ff    <= req_bus.data_byte;
         s0_present_ff <= req_bus.byte_present;
         s0_eos_ff     <= req_bus.end_of_stream;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff    <= 1'b0;
         phase_ff       <= fkw_pkg::PH_HEAD_MARK;
         fbc_ff         <= '0;
         word_ff        <= '0;
         name_ff        <= '0;
         type_ff        <= fkw_pkg::TYPE_NONE;
         declared_ff    <= '0;
         elements_ff    <= '0;
         fbl_ff         <= '0;
         offset_ff      <= '0;
         start_ff       <= '0;
         index_ff       <= '0;
         halted_ff      <= 1'b0;
         max_records_ff <= fkw_pkg::MAX_RECORDS_RESET;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         count_ff       <= '0;
      end else begin
         s0_valid_ff    <= s0_valid_in;
         phase_ff       <= phase_in;
         fbc_ff         <= fbc_in;
         word_ff        <= word_in;
         name_ff        <= name_in;
         type_ff        <= type_in;
         declared_ff    <= declared_in;
         elements_ff    <= elements_in;
         fbl_ff         <= fbl_in;
         offset_ff      <= offset_in;
         start_ff       <= start_in;
         index_ff       <= index_in;
         halted_ff      <= halted_in;
         max_records_ff <= max_records_in;
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         count_ff       <= count_in;
      end
   end

endmodule

// ----- verif/fortran_record_keyword_scanner_tb.sv -----
// Self-checking bench for the Fortran record keyword scanner: streams framed keyword
// files byte by byte, predicts every result word and checks the result channel.
// Depends on fkw_pkg, the channel interfaces and the scanner top level.
`timescale 1ns / 100ps

module fortran_record_keyword_scanner_tb;
   import fkw_pkg::*;

   localparam int HALF_PERIOD  = 4;
   localparam int HOLD_CYCLES  = 400;      // long receiver hold-off in the backlog phase
   localparam int SETTLE       = 6;        // cycles past the result latency
   localparam int PHASE_BYTES  = 230;
   localparam int PHASE_RECS   = 4;
   localparam int TIMEOUT_NS   = 3_200_000;

   // one input word: a file byte, its present flag and the end-of-stream mark
   typedef struct packed {
      logic [7:0] data;
      logic       present;
      logic       eos;
   } scan_word_type;

   // one result word as seen on the result channel
   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] name;
      logic [2:0]  code;
      logic [30:0] count;
      logic [47:0] offs;
      logic [15:0] total;
      logic        last;
   } scan_result_type;

   // how the stream is closed once the paced phases are done
   typedef enum int {
      FIN_CLEAN, FIN_CLEAN_ON_BYTE, FIN_CUT_MARK, FIN_CUT_HEADER, FIN_CUT_FRAME,
      FIN_BAD_TYPE, FIN_NEG_COUNT, FIN_NEG_FRAME, FIN_TABLE_FULL, FIN_HUGE_COUNT
   } finish_kind_type;

   // Scoreboard: carries its own copy of the parser and the queue of results still
   // owed by the block. note_word advances the parser, check_result pops and compares.
   class record_scoreboard;
      scan_result_type owed_q[$];
      logic [15:0]  limit;
      logic [2:0]   step;
      logic [2:0]   byte_pos;
      logic [31:0]  shift_word;
      logic [63:0]  shift_name;
      logic [2:0]   held_code;
      logic [31:0]  count_decl;
      logic [63:0]  elems_summed;
      logic [63:0]  skip_left;
      logic [47:0]  file_pos;
      logic [47:0]  rec_base;
      logic [15:0]  rec_next;
      bit           stopped;
      int unsigned  failures;
      int unsigned  records_seen;
      int unsigned  results_seen;

      function new();
         limit        = MAX_RECORDS_RESET;
         step         = PH_HEAD_MARK;
         byte_pos     = '0;
         shift_word   = '0;
         shift_name   = '0;
         held_code    = TYPE_NONE;
         count_decl   = '0;
         elems_summed = '0;
         skip_left    = '0;
         file_pos     = '0;
         rec_base     = '0;
         rec_next     = '0;
         stopped      = 1'b0;
         failures     = 0;
         records_seen = 0;
         results_seen = 0;
      endfunction

      static function logic [31:0] tag_of(logic [2:0] code);
         case (code)
            TYPE_INTE: return TAG_INTE;
            TYPE_REAL: return TAG_REAL;
            TYPE_DOUB: return TAG_DOUB;
            TYPE_CHAR: return TAG_CHAR;
            TYPE_LOGI: return TAG_LOGI;
            TYPE_MESS: return TAG_MESS;
            default:   return 32'h0;
         endcase
      endfunction

      static function int unsigned unit_bytes(logic [2:0] code);
         if (code == TYPE_LOGI) return 1;
         if (code == TYPE_DOUB || code == TYPE_CHAR) return 8;
         return 4;
      endfunction

      function logic [2:0] code_of(logic [31:0] tag);
         for (int c = TYPE_INTE; c <= TYPE_MESS; c++)
            if (tag_of(3'(c)) == tag) return 3'(c);
         return TYPE_NONE;
      endfunction

      function void set_limit(logic [15:0] v);
         limit = v;
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      function void owe(logic [1:0] kind, logic [63:0] name, logic [2:0] code,
                        logic [30:0] count, logic [47:0] offs, logic [15:0] total);
         scan_result_type r;
         r.kind  = kind;
         r.name  = name;
         r.code  = code;
         r.count = count;
         r.offs  = offs;
         r.total = total;
         r.last  = 1'b0;
         owed_q.push_back(r);
      endfunction

      function void raise_format();
         owe(KIND_FORMAT, '0, TYPE_NONE, '0, rec_base, rec_next);
         stopped = 1'b1;
      endfunction

      function void close_record();
         bit full;
         full = (rec_next >= limit) || (rec_next == 16'hFFFF);
         owe(full ? KIND_FULL : KIND_RECORD, shift_name, held_code, count_decl[30:0],
             rec_base, rec_next);
         if (full) stopped = 1'b1;
         else rec_next = rec_next + 16'd1;
         step     = PH_HEAD_MARK;
         byte_pos = '0;
      endfunction

      function void take_byte(logic [7:0] b);
         case (step)
            PH_NAME: begin
               shift_name = {shift_name[55:0], b};
               if (byte_pos < 3'd7) begin
                  byte_pos++;
               end else begin
                  byte_pos = '0;
                  step     = PH_COUNT;
               end
            end
            PH_FRAME_SKIP: begin
               if (skip_left > 0) skip_left--;
               if (skip_left == 0) begin
                  if (elems_summed >= 64'(count_decl)) begin
                     close_record();
                  end else begin
                     step     = PH_FRAME_LEN;
                     byte_pos = '0;
                  end
               end
            end
            PH_HEAD_MARK, PH_COUNT, PH_TYPE, PH_HEAD_CLOSE, PH_FRAME_LEN: begin
               if (step == PH_HEAD_MARK && byte_pos == 0) rec_base = file_pos;
               shift_word = {shift_word[23:0], b};
               if (byte_pos < 3'd3) begin
                  byte_pos++;
                  return;
               end
               byte_pos = '0;
               if (step == PH_HEAD_MARK) begin
                  shift_name = '0;
                  step       = PH_NAME;
               end else if (step == PH_COUNT) begin
                  count_decl = shift_word;
                  step       = PH_TYPE;
               end else if (step == PH_TYPE) begin
                  held_code = code_of(shift_word);
                  if (held_code == TYPE_NONE) raise_format();
                  else step = PH_HEAD_CLOSE;
               end else if (step == PH_HEAD_CLOSE) begin
                  // a negative count is caught only once the closing marker is in
                  if (count_decl[31]) begin
                     raise_format();
                     return;
                  end
                  elems_summed = '0;
                  if (count_decl == 0) close_record();
                  else step = PH_FRAME_LEN;
               end else begin
                  if (shift_word[31]) begin
                     raise_format();
                     return;
                  end
                  elems_summed += 64'(shift_word / unit_bytes(held_code));
                  skip_left     = 64'(shift_word) + 64'd4;
                  step          = PH_FRAME_SKIP;
               end
            end
            default: raise_format();
         endcase
      endfunction

      function void note_word(scan_word_type w);
         int owed_before;
         owed_before = owed_q.size();
         if (stopped) return;
         if (w.present) begin
            take_byte(w.data);
            file_pos = file_pos + 48'd1;
         end
         if (!stopped && w.eos) begin
            if (step == PH_HEAD_MARK && byte_pos == 0) begin
               owe(KIND_END, '0, TYPE_NONE, '0, file_pos, rec_next);
               stopped = 1'b1;
            end else begin
               raise_format();
            end
         end
         if (owed_q.size() > owed_before) owed_q[owed_q.size() - 1].last = 1'b1;
      endfunction

      function void flag(string what, bit has_want, scan_result_type want,
                         scan_result_type got);
         failures++;
         if (failures > 10) return;
         $display("[%0t] %s", $time, what);
         if (has_want)
            $display("   want kind=%0d name=%h type=%0d count=%0d offset=%0d total=%0d last=%0b",
                     want.kind, want.name, want.code, want.count, want.offs, want.total,
                     want.last);
         $display("   got  kind=%0d name=%h type=%0d count=%0d offset=%0d total=%0d last=%0b",
                  got.kind, got.name, got.code, got.count, got.offs, got.total, got.last);
      endfunction

      function void check_result(scan_result_type got);
         scan_result_type want;
         results_seen++;
         if (owed_q.size() == 0) begin
            flag("result word with nothing owed", 1'b0, got, got);
            return;
         end
         want = owed_q.pop_front();
         if (want.kind == KIND_RECORD) records_seen++;
         if (got.kind !== want.kind || got.name !== want.name || got.code !== want.code ||
             got.count !== want.count || got.offs !== want.offs ||
             got.total !== want.total || got.last !== want.last)
            flag("result word mismatch", 1'b1, want, got);
      endfunction
   endclass

   logic clock;
   logic reset;

   fkw_req_if req ();
   fkw_rsp_if rsp ();
   fkw_csr_if csr ();

   fortran_record_keyword_scanner dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req),
      .rsp_bus (rsp),
      .csr_bus (csr)
   );

   record_scoreboard sb = new();

   scan_word_type   stream_q[$];    // file words waiting to be offered
   int              src_gap_pct;    // chance that the sender idles before a word, drawn again after each idle
   int              sink_stall_pct; // chance per cycle that the receiver drops ready
   bit              hold_request;   // ask the receiver for one long hold-off
   int unsigned     bytes_sent;
   finish_kind_type closing;

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // Hard stop in case the block hangs or stops returning results.
   initial begin
      #TIMEOUT_NS;
      $display("timeout: %0d result words still owed", sb.pending());
      $display("fortran_record_keyword_scanner verification failed");
      $finish;
   end

   // Receiver: drive ready on the falling edge. A hold request pins ready low for the
   // hold-off set by HOLD_CYCLES so the result queue fills and the block backs up its input.
   initial begin
      int held;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            held         = 0;
            while (held < HOLD_CYCLES) begin
               rsp.ready <= 1'b0;
               held++;
               @(negedge clock);
            end
         end
         rsp.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   // Result monitor: sample on the rising edge, hand every accepted word to the scoreboard.
   always @(posedge clock) begin
      scan_result_type got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.kind  = rsp.result_kind;
         got.name  = rsp.record_name;
         got.code  = rsp.type_code;
         got.count = rsp.element_count;
         got.offs  = rsp.start_offset;
         got.total = rsp.record_total;
         got.last  = rsp.last_of_run;
         sb.check_result(got);
      end
   end

   // ---------------------------------------------------------------------------------
   // File builders: append words to stream_q. Bare words (no byte, no end mark) are
   // sprinkled in at random; the block must ignore them.
   // ---------------------------------------------------------------------------------
   function void push_byte(logic [7:0] b);
      scan_word_type w;
      if ($urandom_range(24) == 0) begin
         w.data    = 8'($urandom);
         w.present = 1'b0;
         w.eos     = 1'b0;
         stream_q.push_back(w);
      end
      w.data    = b;
      w.present = 1'b1;
      w.eos     = 1'b0;
      stream_q.push_back(w);
   endfunction

   function void push_bare_end();
      scan_word_type w;
      w.data    = 8'($urandom);
      w.present = 1'b0;
      w.eos     = 1'b1;
      stream_q.push_back(w);
   endfunction

   // big-endian 32-bit field
   function void push_word32(logic [31:0] v);
      for (int i = 3; i >= 0; i--) push_byte(v[8*i +: 8]);
   endfunction

   function void push_header(logic [63:0] name, logic [31:0] tag, logic [31:0] count);
      push_word32($urandom);     // opening marker, never checked
      for (int i = 7; i >= 0; i--) push_byte(name[8*i +: 8]);
      push_word32(count);
      push_word32(tag);
      push_word32($urandom);     // closing marker
   endfunction

   // Data frames until the summed elements reach count. Mostly short frames, some
   // of them empty or too short to hold one element; now and then one frame that
   // covers the whole count at once.
   function void push_frames(logic [2:0] code, int unsigned count);
      longint unsigned got;
      int unsigned     unit;
      int unsigned     len;
      unit = record_scoreboard::unit_bytes(code);
      got  = 0;
      while (got < count) begin
         if ($urandom_range(7) == 0) len = count * unit + $urandom_range(unit);
         else len = $urandom_range(4 * unit + 3);
         push_word32(len);
         repeat (len) push_byte(8'($urandom));
         push_word32($urandom);
         got += len / unit;
      end
   endfunction

   function int unsigned pick_count();
      return ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
   endfunction

   function void push_record(logic [2:0] code, int unsigned count);
      push_header({$urandom, $urandom}, record_scoreboard::tag_of(code), count);
      push_frames(code, count);
   endfunction

   // words after the block has stopped: all of them must be ignored
   function void push_noise();
      scan_word_type w;
      repeat ($urandom_range(6, 16)) begin
         w.data    = 8'($urandom);
         w.present = 1'($urandom_range(1));
         w.eos     = 1'($urandom_range(1));
         stream_q.push_back(w);
      end
   endfunction

   // ---------------------------------------------------------------------------------
   // Drivers. Inputs move on the falling edge; handshakes are sampled on the rising one.
   // ---------------------------------------------------------------------------------
   task automatic send_word(input scan_word_type w);
      while ($urandom_range(99) < src_gap_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid         <= 1'b1;
      req.data_byte     <= w.data;
      req.byte_present  <= w.present;
      req.end_of_stream <= w.eos;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.note_word(w);
      if (w.present) bytes_sent++;
      @(negedge clock);
   endtask

   // offer every queued word, then drop valid
   task automatic flush_stream();
      scan_word_type w;
      while (stream_q.size() != 0) begin
         w = stream_q.pop_front();
         send_word(w);
      end
      req.valid <= 1'b0;
   endtask

   // wait until nothing is owed, then let the pipeline settle
   task automatic drain();
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_limit(input logic [15:0] v);
      csr.valid       <= 1'b1;
      csr.max_records <= v;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      sb.set_limit(v);
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   task automatic set_pacing(input int mode);
      case (mode)
         0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
         1: begin src_gap_pct = 59; sink_stall_pct = 0;  end
         2: begin src_gap_pct = 0;  sink_stall_pct = 59; end
         default: begin src_gap_pct = 16; sink_stall_pct = 16; end
      endcase
   endtask

   // Close the file one way or another. Every path stops the block, so the words
   // queued after the closing point only prove that it stays quiet.
   task automatic close_stream(input finish_kind_type fk);
      logic [2:0]  code;
      int unsigned count;
      code  = 3'($urandom_range(TYPE_INTE, TYPE_MESS));
      count = $urandom_range(1, 6);
      case (fk)
         FIN_CLEAN: begin
            push_record(code, pick_count());
            push_bare_end();
         end
         FIN_CLEAN_ON_BYTE: begin
            // end mark on the byte that completes a record: record word, then end word
            push_record(code, pick_count());
            stream_q[stream_q.size() - 1].eos = 1'b1;
         end
         FIN_CUT_MARK: begin
            push_record(code, pick_count());
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
            push_bare_end();
         end
         FIN_CUT_HEADER: begin
            push_header({$urandom, $urandom}, record_scoreboard::tag_of(code), count);
            repeat ($urandom_range(1, 20)) void'(stream_q.pop_back());
            stream_q[stream_q.size() - 1].eos = 1'b1;
         end
         FIN_CUT_FRAME: begin
            push_record(code, count);
            repeat ($urandom_range(1, 4)) void'(stream_q.pop_back());
            push_bare_end();
         end
         FIN_BAD_TYPE: begin
            push_header({$urandom, $urandom},
                        record_scoreboard::tag_of(code) ^ (32'h1 << $urandom_range(31)),
                        count);
         end
         FIN_NEG_COUNT: begin
            push_header({$urandom, $urandom}, record_scoreboard::tag_of(code),
                        {1'b1, 31'($urandom)});
         end
         FIN_NEG_FRAME: begin
            push_header({$urandom, $urandom}, record_scoreboard::tag_of(code), count);
            push_word32({1'b1, 31'($urandom)});
         end
         FIN_TABLE_FULL: begin
            // limit at or below the records already found: the next one is refused
            write_limit(16'($urandom_range(1, int'(sb.rec_next))));
            push_record(code, pick_count());
         end
         default: begin
            // largest count and largest frame length, cut off inside the frame
            push_header({$urandom, $urandom}, record_scoreboard::tag_of(code),
                        32'h7FFF_FFFF);
            push_word32(32'h7FFF_FFFF);
            repeat ($urandom_range(1, 8)) push_byte(8'($urandom));
            stream_q[stream_q.size() - 1].eos = 1'b1;
         end
      endcase
      push_noise();
      flush_stream();
   endtask

   // ---------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------
   initial begin
      int recs;
      reset             = 1'b1;
      req.valid         = 1'b0;
      req.data_byte     = '0;
      req.byte_present  = 1'b0;
      req.end_of_stream = 1'b0;
      csr.valid         = 1'b0;
      csr.max_records   = '0;
      src_gap_pct       = 0;
      sink_stall_pct    = 0;
      hold_request      = 1'b0;
      bytes_sent        = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed opening: a limit of one, one empty record whose name toggles every
      // byte bit, and a bare word inside the header.
      write_limit(16'd1);
      push_header(64'h00FF_00FF_FF00_FF00, TAG_LOGI, 32'd0);
      stream_q.insert(6, scan_word_type'{8'hA5, 1'b0, 1'b0});
      flush_stream();
      drain();
      write_limit(16'hFFFF);

      // Paced phases: no idling, sender gaps, receiver stalls, then both.
      // The first six records walk through every type code.
      for (int mode = 0; mode < 4; mode++) begin
         set_pacing(mode);
         recs = 0;
         while (stream_q.size() < PHASE_BYTES || recs < PHASE_RECS ||
                (mode == 0 && recs < 6)) begin
            if (mode == 0 && recs < 6) push_record(3'(TYPE_INTE + recs), pick_count());
            else push_record(3'($urandom_range(TYPE_INTE, TYPE_MESS)), pick_count());
            recs++;
         end
         flush_stream();
         drain();
         write_limit(16'($urandom_range(int'(sb.rec_next) + 200, 65535)));
      end

      // Backlog: receiver holds off while the sender streams short records flat out.
      set_pacing(0);
      hold_request = 1'b1;
      repeat (10) push_record(3'($urandom_range(TYPE_INTE, TYPE_MESS)), 0);
      flush_stream();
      drain();
      write_limit(16'($urandom_range(int'(sb.rec_next) + 50, 65535)));

      // Closing: random pacing, one randomly chosen way of ending the file.
      set_pacing($urandom_range(3));
      closing = finish_kind_type'($urandom_range(FIN_CLEAN, FIN_HUGE_COUNT));
      close_stream(closing);
      drain();

      $display("Run covered %0d file bytes, %0d records reported, %0d result words checked,",
               bytes_sent, sb.records_seen, sb.results_seen);
      $display("four pacing modes, a result backlog, and a stream closed by %s.",
               closing.name());
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("fortran_record_keyword_scanner verification clean");
      end else begin
         $display("%0d failures, %0d result words never seen", sb.failures, sb.pending());
         $display("fortran_record_keyword_scanner verification failed");
      end
      $finish;
   end

endmodule
